// ----- sv/mte_pkg.sv -----
// shared types, codes and key tables of the multi-tap text entry block
package mte_pkg;

    localparam int DEF_SCREEN_WIDTH = 240;
    localparam int DEF_TEXT_DEPTH   = 64;
    localparam int DEF_GRID_TOP     = 64;
    localparam int DEF_ROW_HEIGHT   = 43;

    localparam logic [6:0]  CAP_RESET    = 7'd64;
    localparam logic [15:0] WINDOW_RESET = 16'd900;

    localparam logic [3:0] NO_KEY    = 4'd15;
    localparam logic [3:0] SPACE_KEY = 4'd9;

    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_WINDOW   = 1'b1;

    localparam logic [1:0] F_POLL   = 2'd0;
    localparam logic [1:0] F_TAP    = 2'd1;
    localparam logic [1:0] F_CANCEL = 2'd2;
    localparam logic [1:0] F_START  = 2'd3;

    localparam logic [1:0] ST_EDIT    = 2'd0;
    localparam logic [1:0] ST_ACCEPT  = 2'd1;
    localparam logic [1:0] ST_CANCEL  = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_APPEND  = 3'd1;
    localparam logic [2:0] ACT_REPLACE = 3'd2;
    localparam logic [2:0] ACT_DELETE  = 3'd3;
    localparam logic [2:0] ACT_TOGGLE  = 3'd4;
    localparam logic [2:0] ACT_EMIT    = 3'd5;
    localparam logic [2:0] ACT_START   = 3'd6;

    typedef struct packed {
        logic [1:0]  func;
        logic [8:0]  touch_x;
        logic [8:0]  touch_y;
        logic [31:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] action;
        logic [5:0] char_pos;
        logic [6:0] char_code;
        logic [5:0] text_length;
        logic       upper_mode;
        logic       last;
    } t_out_item;

    function automatic logic [4:0] key_len(input logic [3:0] key);
        logic [4:0] n;
        case (key)
            4'd0:    n = 5'd17;
            4'd6:    n = 5'd5;
            4'd8:    n = 5'd5;
            4'd9:    n = 5'd2;
            default: n = 5'd4;
        endcase
        return n;
    endfunction

    function automatic logic [6:0] key_char(input logic [3:0] key, input logic [4:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (key)
            4'd0: begin
                case (idx)
                    5'd0:    c = "1";
                    5'd1:    c = ".";
                    5'd2:    c = ",";
                    5'd3:    c = "-";
                    5'd4:    c = "_";
                    5'd5:    c = "@";
                    5'd6:    c = "#";
                    5'd7:    c = "$";
                    5'd8:    c = "%";
                    5'd9:    c = "&";
                    5'd10:   c = "*";
                    5'd11:   c = "+";
                    5'd12:   c = "=";
                    5'd13:   c = ":";
                    5'd14:   c = "/";
                    5'd15:   c = "!";
                    5'd16:   c = "?";
                    default: c = 8'h00;
                endcase
            end
            4'd6: begin
                case (idx)
                    5'd0:    c = "p";
                    5'd1:    c = "q";
                    5'd2:    c = "r";
                    5'd3:    c = "s";
                    5'd4:    c = "7";
                    default: c = 8'h00;
                endcase
            end
            4'd8: begin
                case (idx)
                    5'd0:    c = "w";
                    5'd1:    c = "x";
                    5'd2:    c = "y";
                    5'd3:    c = "z";
                    5'd4:    c = "9";
                    default: c = 8'h00;
                endcase
            end
            4'd9: begin
                case (idx)
                    5'd0:    c = " ";
                    5'd1:    c = "0";
                    default: c = 8'h00;
                endcase
            end
            4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd7: begin
                // three letters from a, d, g, j, m or t, then the digit
                if (idx < 5'd3) begin
                    case (key)
                        4'd1:    c = 8'h61 + 8'(idx);
                        4'd2:    c = 8'h64 + 8'(idx);
                        4'd3:    c = 8'h67 + 8'(idx);
                        4'd4:    c = 8'h6a + 8'(idx);
                        4'd5:    c = 8'h6d + 8'(idx);
                        default: c = 8'h74 + 8'(idx);
                    endcase
                end else if (idx == 5'd3) begin
                    c = (key == 4'd7) ? "8" : 8'h31 + 8'(key);
                end
            end
            default: c = 8'h00;
        endcase
        return c[6:0];
    endfunction

endpackage

// ----- sv/multitap_text_entry.sv -----
// multi-tap text entry block: decode, edit state, text memory and readout
//
// Each event is accepted when o_in_ready is high and its result is loaded into the output
// register after the key decode state and then the execute state, which waits for the output
// register to free up. An OK tap on non-empty text streams the stored characters out of the
// text memory, one per cycle while the output register is free, through its single
// registered read port; o_in_ready stays low until the last character has been loaded
// into the output register. The text store has no reset: only written positions are
// ever read back.
module multitap_text_entry #(
    parameter int SCREEN_WIDTH = mte_pkg::DEF_SCREEN_WIDTH,
    parameter int TEXT_DEPTH   = mte_pkg::DEF_TEXT_DEPTH,
    parameter int GRID_TOP     = mte_pkg::DEF_GRID_TOP,
    parameter int ROW_HEIGHT   = mte_pkg::DEF_ROW_HEIGHT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mte_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mte_pkg::t_out_item o_out_item,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import mte_pkg::*;

    localparam int CW = $clog2(TEXT_DEPTH);

    localparam logic [8:0] GT9  = 9'(GRID_TOP);
    localparam logic [9:0] RH1  = 10'(ROW_HEIGHT);
    localparam logic [9:0] RH2  = 10'(2 * ROW_HEIGHT);
    localparam logic [9:0] RH3  = 10'(3 * ROW_HEIGHT);
    localparam logic [9:0] RH4  = 10'(4 * ROW_HEIGHT);
    localparam logic [9:0] W3A  = 10'(SCREEN_WIDTH / 3);
    localparam logic [9:0] W3B  = 10'(2 * (SCREEN_WIDTH / 3));
    localparam logic [9:0] W4A  = 10'(SCREEN_WIDTH / 4);
    localparam logic [9:0] W4B  = 10'(2 * (SCREEN_WIDTH / 4));
    localparam logic [9:0] W4C  = 10'(3 * (SCREEN_WIDTH / 4));
    localparam logic [6:0] DEP7 = 7'(TEXT_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DEC  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam logic [2:0] D_NONE  = 3'd0;
    localparam logic [2:0] D_KEY   = 3'd1;
    localparam logic [2:0] D_SHIFT = 3'd2;
    localparam logic [2:0] D_BACK  = 3'd3;
    localparam logic [2:0] D_OK    = 3'd4;

    logic [1:0]  r_state, n_state;
    t_in_item    r_in;
    logic [6:0]  r_capacity;
    logic [15:0] r_window;

    logic [CW-1:0] r_count, n_count;
    logic          r_upper, n_upper;
    logic [3:0]    r_pkey, n_pkey;
    logic [4:0]    r_pidx, n_pidx;
    logic [31:0]   r_last_time, n_last_time;
    logic          r_active, n_active;
    logic [CW-1:0] r_idx, n_idx;

    logic [2:0]  r_kind, d_kind;
    logic [3:0]  r_key, d_key;
    logic        r_expired;

    logic [6:0]  r_mem [TEXT_DEPTH];
    logic [6:0]  r_rd_data;
    logic          w_en;
    logic [CW-1:0] w_addr;
    logic [6:0]    w_data;

    logic        r_out_valid;
    t_out_item   r_out, n_out;
    logic        out_free, ld;

    // key decode
    logic [9:0] dy, x10;
    logic [1:0] row, col3;
    logic [31:0] diff;

    always_comb begin
        x10    = 10'(r_in.touch_x);
        dy     = 10'(r_in.touch_y - GT9);
        row    = (dy < RH1) ? 2'd0 : (dy < RH2) ? 2'd1 : 2'd2;
        col3   = (x10 >= W3B) ? 2'd2 : (x10 >= W3A) ? 2'd1 : 2'd0;
        d_kind = D_NONE;
        d_key  = 4'(row) * 4'd3 + 4'(col3);
        if (r_in.func == F_TAP && r_in.touch_y >= GT9) begin
            if (dy < RH3) begin
                d_kind = D_KEY;
            end else if (dy < RH4) begin
                if (x10 < W4A) begin
                    d_kind = D_SHIFT;
                end else if (x10 < W4B) begin
                    d_kind = D_KEY;
                    d_key  = SPACE_KEY;
                end else if (x10 < W4C) begin
                    d_kind = D_BACK;
                end else begin
                    d_kind = D_OK;
                end
            end
        end
        diff = r_in.time_ms - r_last_time;
    end

    // execute
    logic [6:0]  cap7, limit, ch;
    logic        full, repeat_tap;
    logic [4:0]  nxt_idx;
    logic [CW:0] idx_p1;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        cap7       = (r_capacity > DEP7) ? DEP7 : r_capacity;
        limit      = (cap7 == 7'd0) ? 7'd0 : cap7 - 7'd1;
        full       = 7'(r_count) >= limit;
        repeat_tap = (r_key == r_pkey) && !r_expired && (r_count != '0);
        nxt_idx    = (r_pidx + 5'd1 == key_len(r_key)) ? 5'd0 : r_pidx + 5'd1;
        ch         = key_char(r_key, repeat_tap ? nxt_idx : 5'd0);
        if (r_upper && ch >= 7'h61 && ch <= 7'h7a) begin
            ch = ch - 7'd32;
        end
        idx_p1 = (CW+1)'(r_idx) + 1'b1;

        n_state     = r_state;
        n_count     = r_count;
        n_upper     = r_upper;
        n_pkey      = r_pkey;
        n_pidx      = r_pidx;
        n_last_time = r_last_time;
        n_active    = r_active;
        n_idx       = r_idx;
        w_en        = 1'b0;
        w_addr      = r_count;
        w_data      = ch;
        ld          = 1'b0;
        n_out       = '0;
        n_out.status = ST_EDIT;
        n_out.action = ACT_NONE;
        n_out.last   = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    ld      = 1'b1;
                    n_state = S_IDLE;
                    if (r_in.func == F_START) begin
                        n_count      = '0;
                        n_upper      = 1'b0;
                        n_pkey       = NO_KEY;
                        n_pidx       = 5'd0;
                        n_last_time  = '0;
                        n_active     = 1'b1;
                        n_out.action = ACT_START;
                    end else if (!r_active) begin
                        n_out.status = ST_IGNORED;
                    end else if (r_in.func == F_CANCEL) begin
                        n_active     = 1'b0;
                        n_out.status = ST_CANCEL;
                    end else begin
                        case (r_kind)
                            D_KEY: begin
                                n_last_time = r_in.time_ms;
                                if (repeat_tap) begin
                                    n_pidx         = nxt_idx;
                                    w_en           = 1'b1;
                                    w_addr         = r_count - 1'b1;
                                    n_out.char_pos = 6'(w_addr);
                                    n_out.char_code = ch;
                                    n_out.action   = ACT_REPLACE;
                                end else if (!full) begin
                                    n_pkey          = r_key;
                                    n_pidx          = 5'd0;
                                    w_en            = 1'b1;
                                    n_out.char_pos  = 6'(r_count);
                                    n_out.char_code = ch;
                                    n_count         = r_count + 1'b1;
                                    n_out.action    = ACT_APPEND;
                                end
                            end
                            D_SHIFT: begin
                                n_upper      = !r_upper;
                                n_pkey       = NO_KEY;
                                n_out.action = ACT_TOGGLE;
                            end
                            D_BACK: begin
                                if (r_count != '0) begin
                                    n_count        = r_count - 1'b1;
                                    n_pkey         = NO_KEY;
                                    n_out.char_pos = 6'(n_count);
                                    n_out.action   = ACT_DELETE;
                                end
                            end
                            D_OK: begin
                                n_active     = 1'b0;
                                n_out.status = ST_ACCEPT;
                                if (r_count != '0) begin
                                    ld      = 1'b0;
                                    n_idx   = '0;
                                    n_state = S_EMIT;
                                end
                            end
                            default: begin
                            end
                        endcase
                        if (r_expired && r_kind != D_KEY && r_kind != D_OK) begin
                            n_pkey = NO_KEY;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    ld              = 1'b1;
                    n_out.status    = ST_ACCEPT;
                    n_out.action    = ACT_EMIT;
                    n_out.char_pos  = 6'(r_idx);
                    n_out.char_code = r_rd_data;
                    n_out.last      = (idx_p1 == (CW+1)'(r_count));
                    if (n_out.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = idx_p1[CW-1:0];
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out.text_length = 6'(n_count);
        n_out.upper_mode  = n_upper;
    end

    // text memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd_data <= r_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (r_state == S_DEC) begin
            r_kind    <= d_kind;
            r_key     <= d_key;
            r_expired <= diff > 32'(r_window);
        end
        if (ld) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_capacity  <= CAP_RESET;
            r_window    <= WINDOW_RESET;
            r_count     <= '0;
            r_upper     <= 1'b0;
            r_pkey      <= NO_KEY;
            r_pidx      <= 5'd0;
            r_last_time <= '0;
            r_active    <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_upper     <= n_upper;
            r_pkey      <= n_pkey;
            r_pidx      <= n_pidx;
            r_last_time <= n_last_time;
            r_active    <= n_active;
            r_idx       <= n_idx;
            r_out_valid <= ld || (r_out_valid && !i_out_ready);
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_CAPACITY: r_capacity <= i_cfg_data[6:0];
                    CFG_WINDOW:   r_window   <= i_cfg_data;
                    default:      r_window   <= r_window;
                endcase
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
